// ===== hdl/exptok_pkg.sv =====
// Package: token kinds and character codes shared by the expression tokenizer.
package exptok_pkg;

    // Token kinds as carried on the output tuser
    localparam logic [3:0] TK_END    = 4'd0;
    localparam logic [3:0] TK_NUMBER = 4'd1;
    localparam logic [3:0] TK_NAME   = 4'd2;
    localparam logic [3:0] TK_PLUS   = 4'd3;
    localparam logic [3:0] TK_MINUS  = 4'd4;
    localparam logic [3:0] TK_MUL    = 4'd5;
    localparam logic [3:0] TK_DIV    = 4'd6;
    localparam logic [3:0] TK_LPAREN = 4'd7;
    localparam logic [3:0] TK_RPAREN = 4'd8;
    localparam logic [3:0] TK_EQUAL  = 4'd9;
    localparam logic [3:0] TK_SEMI   = 4'd10;
    localparam logic [3:0] TK_ERROR  = 4'd11;

    // ASCII codes
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_DIGIT_0    = 8'h30;
    localparam logic [7:0] CH_DIGIT_9    = 8'h39;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_SEMI       = 8'h3B;

    // Decimal radix for the number accumulator
    localparam int RADIX = 10;

endpackage

// ===== hdl/expression_tokenizer.sv =====
// Expression tokenizer: character stream in, token stream out.
//
// One character word is taken per cycle on the slave side while ready. Whitespace
// (tab to carriage return, and space) is skipped and ends any pending token. Digit
// runs build a saturating number token (overflow flagged); letter, digit and
// underscore runs that start with a letter or underscore build a name token
// holding the first NAME_CHARS characters (truncation flagged). Each of
// + - * / ( ) = ; gives its own token and any other code gives an error token
// carrying the code. A word with tlast set flushes the pending token and then
// emits an end token; a word with tuser low carries no character. A word
// produces zero to three tokens in the order: flushed number or name, token
// of the character (or the flushed token on end of text), end token. tlast
// on the master side marks the final token of each input word. Rate: a word
// that yields at most one token sustains one word per clock while the output
// is ready; a word yielding more tokens holds off the next word, because the
// single result register holds all tokens of one word and the next word is
// taken only in the cycle its last token leaves. The first token of a word is
// registered and comes out in the cycle after the word is taken.
module expression_tokenizer #(
    parameter int NAME_CHARS  = 8,
    parameter int NUMBER_BITS = 31
) (
    input  logic clk,
    input  logic rst_n,

    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_code
    input  logic       s_axis_tuser,   // has_char
    input  logic       s_axis_tlast,   // end_of_text

    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // From bit 0 up: number_value, number_overflow, name_text, name_length,
    // name_truncated, bad_char, zero padding to whole bytes
    output logic [((NUMBER_BITS + 8 * NAME_CHARS + 21) / 8) * 8 - 1:0] m_axis_tdata,
    output logic [3:0] m_axis_tuser,   // token_kind
    output logic       m_axis_tlast    // last_of_run
);

    localparam int NAME_BITS = 8 * NAME_CHARS;
    localparam int DATA_BITS = NUMBER_BITS + 1 + NAME_BITS + 4 + 1 + 8;
    localparam int TDATA_BITS = ((NUMBER_BITS + 8 * NAME_CHARS + 21) / 8) * 8;

    localparam logic [NUMBER_BITS-1:0] NUM_MAX = {NUMBER_BITS{1'b1}};
    localparam logic [3:0] NAME_LIM = 4'(NAME_CHARS);
    localparam logic [NUMBER_BITS+3:0] RADIX_W = (NUMBER_BITS + 4)'(exptok_pkg::RADIX);

    // Scan modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_NUM  = 2'd1;
    localparam logic [1:0] MODE_NAME = 2'd2;

    typedef struct packed {
        logic [3:0]             kind;
        logic [NUMBER_BITS-1:0] value;
        logic                   overflow;
        logic [NAME_BITS-1:0]   text;
        logic [3:0]             length;
        logic                   truncated;
        logic [7:0]             bad;
    } token_t;

    // Scanner state
    logic [1:0]             mode_reg, mode_next;
    logic [NUMBER_BITS-1:0] acc_reg, acc_next;
    logic                   sat_reg, sat_next;
    logic [NAME_BITS-1:0]   nbuf_reg, nbuf_next;
    logic [3:0]             ncnt_reg, ncnt_next;
    logic                   novf_reg, novf_next;

    // Result register: flushed token, middle token, end token
    token_t     tok_a_reg, tok_a_next;
    token_t     tok_b_reg, tok_b_next;
    logic [2:0] pend_reg, pend_next;

    logic [2:0] pend_new;
    logic [2:0] pend_drop;
    logic       pend_single;
    logic       in_fire;
    logic       out_fire;

    logic [7:0] ch;
    logic       has_char;
    logic       eot;
    logic       is_digit, is_alpha, is_under, is_space;
    logic [3:0] op_kind;
    logic [NUMBER_BITS+3:0] prod;
    token_t     tok_out;

    function automatic token_t flush_tok(
        input logic [1:0]             mode,
        input logic [NUMBER_BITS-1:0] acc,
        input logic                   sat,
        input logic [NAME_BITS-1:0]   nbuf,
        input logic [3:0]             ncnt,
        input logic                   novf
    );
        token_t t;
        t = '0;
        if (mode == MODE_NUM)
        begin
            t.kind     = exptok_pkg::TK_NUMBER;
            t.value    = acc;
            t.overflow = sat;
        end
        else
        begin
            t.kind      = exptok_pkg::TK_NAME;
            t.text      = nbuf;
            t.length    = ncnt;
            t.truncated = novf;
        end
        return t;
    endfunction

    assign ch       = s_axis_tdata;
    assign has_char = s_axis_tuser;
    assign eot      = s_axis_tlast;

    // Character classes
    always_comb
    begin
        is_digit = ch inside {[exptok_pkg::CH_DIGIT_0:exptok_pkg::CH_DIGIT_9]};
        is_alpha = ch inside {[exptok_pkg::CH_UPPER_A:exptok_pkg::CH_UPPER_Z],
                              [exptok_pkg::CH_LOWER_A:exptok_pkg::CH_LOWER_Z]};
        is_under = (ch == exptok_pkg::CH_UNDERSCORE);
        is_space = ch inside {[exptok_pkg::CH_TAB:exptok_pkg::CH_CR], exptok_pkg::CH_SPACE};
        case (ch)
            exptok_pkg::CH_PLUS:   op_kind = exptok_pkg::TK_PLUS;
            exptok_pkg::CH_MINUS:  op_kind = exptok_pkg::TK_MINUS;
            exptok_pkg::CH_STAR:   op_kind = exptok_pkg::TK_MUL;
            exptok_pkg::CH_SLASH:  op_kind = exptok_pkg::TK_DIV;
            exptok_pkg::CH_LPAREN: op_kind = exptok_pkg::TK_LPAREN;
            exptok_pkg::CH_RPAREN: op_kind = exptok_pkg::TK_RPAREN;
            exptok_pkg::CH_EQUAL:  op_kind = exptok_pkg::TK_EQUAL;
            exptok_pkg::CH_SEMI:   op_kind = exptok_pkg::TK_SEMI;
            default:               op_kind = exptok_pkg::TK_ERROR;
        endcase
    end

    // Handshake: take a new word once the result register empties this cycle
    assign pend_drop     = pend_reg & (pend_reg - 3'd1);
    assign pend_single   = (pend_drop == 3'd0);
    assign m_axis_tvalid = (pend_reg != 3'd0);
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (pend_reg == 3'd0) || (pend_single && m_axis_tready);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Scan step for one word
    always_comb
    begin
        mode_next  = mode_reg;
        acc_next   = acc_reg;
        sat_next   = sat_reg;
        nbuf_next  = nbuf_reg;
        ncnt_next  = ncnt_reg;
        novf_next  = novf_reg;
        tok_a_next = '0;
        tok_b_next = '0;
        pend_new   = 3'd0;
        prod       = '0;

        if (mode_next != MODE_NUM && mode_next != MODE_NAME)
            mode_next = MODE_IDLE;

        if (has_char)
        begin
            if (!((mode_next == MODE_NUM && is_digit) ||
                  (mode_next == MODE_NAME && (is_alpha || is_digit || is_under))))
            begin
                // Character ends the pending token (if any)
                if (mode_next != MODE_IDLE)
                begin
                    tok_a_next  = flush_tok(mode_next, acc_next, sat_next,
                                            nbuf_next, ncnt_next, novf_next);
                    pend_new[0] = 1'b1;
                end
                mode_next = MODE_IDLE;
                acc_next  = '0;
                sat_next  = 1'b0;
                nbuf_next = '0;
                ncnt_next = 4'd0;
                novf_next = 1'b0;
                if (is_space)
                begin
                    mode_next = MODE_IDLE;
                end
                else if (is_digit)
                begin
                    mode_next = MODE_NUM;
                end
                else if (is_alpha || is_under)
                begin
                    mode_next = MODE_NAME;
                end
                else
                begin
                    tok_b_next.kind = op_kind;
                    if (op_kind == exptok_pkg::TK_ERROR)
                        tok_b_next.bad = ch;
                    pend_new[1] = 1'b1;
                end
            end

            // Append the character to the number or name now in progress
            if (mode_next == MODE_NUM)
            begin
                prod = {4'd0, acc_next} * RADIX_W
                     + {{NUMBER_BITS{1'b0}}, ch[3:0] - exptok_pkg::CH_DIGIT_0[3:0]};
                if (sat_next || (prod[NUMBER_BITS+3:NUMBER_BITS] != 4'd0))
                begin
                    acc_next = NUM_MAX;
                    sat_next = 1'b1;
                end
                else
                begin
                    acc_next = prod[NUMBER_BITS-1:0];
                end
            end
            else if (mode_next == MODE_NAME)
            begin
                if (ncnt_next < NAME_LIM)
                begin
                    for (int i = 0; i < NAME_CHARS; i++)
                    begin
                        if (ncnt_next == 4'(i))
                            nbuf_next[8*i +: 8] = ch;
                    end
                    ncnt_next = ncnt_next + 4'd1;
                end
                else
                begin
                    novf_next = 1'b1;
                end
            end
        end

        if (eot)
        begin
            if (mode_next != MODE_IDLE)
            begin
                tok_b_next  = flush_tok(mode_next, acc_next, sat_next,
                                        nbuf_next, ncnt_next, novf_next);
                pend_new[1] = 1'b1;
            end
            mode_next   = MODE_IDLE;
            acc_next    = '0;
            sat_next    = 1'b0;
            nbuf_next   = '0;
            ncnt_next   = 4'd0;
            novf_next   = 1'b0;
            pend_new[2] = 1'b1;
        end

        if (in_fire)
            pend_next = pend_new;
        else if (out_fire)
            pend_next = pend_drop;
        else
            pend_next = pend_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            acc_reg  <= '0;
            sat_reg  <= 1'b0;
            nbuf_reg <= '0;
            ncnt_reg <= 4'd0;
            novf_reg <= 1'b0;
            pend_reg <= 3'd0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (in_fire)
            begin
                mode_reg <= mode_next;
                acc_reg  <= acc_next;
                sat_reg  <= sat_next;
                nbuf_reg <= nbuf_next;
                ncnt_reg <= ncnt_next;
                novf_reg <= novf_next;
            end
        end
    end

    // Token payloads need no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            tok_a_reg <= tok_a_next;
            tok_b_reg <= tok_b_next;
        end
    end

    // Oldest outstanding token goes out first; the end token is all zeros
    always_comb
    begin
        if (pend_reg[0])
            tok_out = tok_a_reg;
        else if (pend_reg[1])
            tok_out = tok_b_reg;
        else
        begin
            tok_out      = '0;
            tok_out.kind = exptok_pkg::TK_END;
        end
        m_axis_tdata = '0;
        m_axis_tdata[DATA_BITS-1:0] = {tok_out.bad, tok_out.truncated, tok_out.length,
                                       tok_out.text, tok_out.overflow, tok_out.value};
    end

    assign m_axis_tuser = tok_out.kind;
    assign m_axis_tlast = pend_single;

    // Idle scanner holds no partial token
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_IDLE) |-> (acc_reg == '0 && ncnt_reg == 4'd0 && nbuf_reg == '0))
        else $error("idle scanner holds partial token");

    // Saturation pins the accumulator at its maximum
    assert property (@(posedge clk) disable iff (!rst_n)
        sat_reg |-> (mode_reg == MODE_NUM && acc_reg == NUM_MAX))
        else $error("saturated number not at maximum");

    // Truncated name has filled every kept character
    assert property (@(posedge clk) disable iff (!rst_n)
        (ncnt_reg <= NAME_LIM) && (!novf_reg || ncnt_reg == NAME_LIM))
        else $error("name count out of step with truncation");

    // End of text leaves an end token queued and the scanner idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_axis_tlast) |=> (pend_reg[2] && mode_reg == MODE_IDLE))
        else $error("end of text not followed by end token");

    // Padding bits above the token fields are zero on every output word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_fire |-> (TDATA_BITS == DATA_BITS || (m_axis_tdata >> DATA_BITS) == '0))
        else $error("padding bits of output word not zero");

endmodule
